// ----- design/salru_pkg.sv -----
// ---------------------------------------------------------------------------
// salru_pkg: shared types and constants for the LRU cache tag lookup
// Field widths, register indexes, reset values, the per-way entry layout
// and the command/status bundles between controller and datapath.
// ---------------------------------------------------------------------------
package salru_pkg;

  // Field widths
  localparam int ADDR_W    = 48;
  localparam int TAG_W     = 48;
  localparam int CNT_W     = 48;
  localparam int LAT_W     = 8;
  localparam int LS_W      = 4;
  localparam int WAY_OUT_W = 2;

  // Configuration port
  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 8;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_LINE_SIZE_LOG2 = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_LRU_MODE       = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_HIT_LATENCY    = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_MISS_LATENCY   = 4'd3;

  // Register reset values
  localparam logic [LS_W-1:0]  RST_LINE_SIZE_LOG2 = 4'd6;
  localparam logic             RST_LRU_MODE       = 1'b1;
  localparam logic [LAT_W-1:0] RST_HIT_LATENCY    = 8'd1;
  localparam logic [LAT_W-1:0] RST_MISS_LATENCY   = 8'd10;

  // Default geometry
  localparam int DEF_SETS = 64;
  localparam int DEF_WAYS = 4;

  // One way of a set row
  typedef struct packed {
    logic             valid;
    logic [TAG_W-1:0] tag;
    logic [CNT_W-1:0] stamp;
  } entry_t;

  // Controller to datapath
  typedef struct packed {
    logic clear_row;   // write a zero row at the clear pointer
    logic lookup;      // take a request, start the set read
    logic look_done;   // commit with the way decided in the lookup cycle
    logic scan_start;  // start the stamp scan at way 0
    logic scan_step;   // compare one more way's stamp
    logic fill_done;   // commit with the scanned victim
  } dp_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic clear_last;  // clear pointer at last set
    logic look_final;  // way known without a scan
    logic scan_last;   // scan pointer at last way
    logic out_free;    // result register can take a new result
  } dp_status_t;

endpackage

// ----- design/salru_ram.sv -----
// ---------------------------------------------------------------------------
// salru_ram: generic single-write, single-read RAM
// One write port, one read port with registered read data.
// ---------------------------------------------------------------------------
module salru_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

// ----- design/salru_dp.sv -----
// ---------------------------------------------------------------------------
// salru_dp: datapath of the LRU cache tag lookup
// Configuration registers, set row RAM, tag compare, victim choice,
// stamp scan, statistics counters and the result register.
// ---------------------------------------------------------------------------
module salru_dp #(
  parameter int SETS = salru_pkg::DEF_SETS,
  parameter int WAYS = salru_pkg::DEF_WAYS
) (
  input  logic                                clk,
  input  logic                                rst,
  input  salru_pkg::dp_cmd_t                  cmd,
  output salru_pkg::dp_status_t               status,
  input  logic [salru_pkg::ADDR_W-1:0]        address,
  input  logic                                cfg_valid,
  input  logic [salru_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]    cfg_data,
  output logic                                rsp_valid,
  input  logic                                rsp_stall,
  output logic                                hit,
  output logic [salru_pkg::LAT_W-1:0]         latency,
  output logic [salru_pkg::WAY_OUT_W-1:0]     way_used,
  output logic [salru_pkg::CNT_W-1:0]         hit_total,
  output logic [salru_pkg::CNT_W-1:0]         miss_total
);
  import salru_pkg::*;

  localparam int SET_BITS = $clog2(SETS);
  localparam int SET_W    = (SETS > 1) ? $clog2(SETS) : 1;
  localparam int WAY_W    = (WAYS > 1) ? $clog2(WAYS) : 1;
  localparam int ROW_W    = WAYS * $bits(entry_t);

  // Configuration registers
  logic [LS_W-1:0]  line_size_log2;
  logic             lru_mode;
  logic [LAT_W-1:0] hit_latency;
  logic [LAT_W-1:0] miss_latency;

  // Request and lookup state
  logic [SET_W-1:0] set_q;
  logic [TAG_W-1:0] tag_q;
  logic [SET_W-1:0] clr_cnt;
  logic [CNT_W-1:0] access_count;
  logic [CNT_W-1:0] hit_count;
  logic [CNT_W-1:0] miss_count;
  logic [WAY_W-1:0] scan_idx;
  logic [WAY_W-1:0] best_way;
  logic [CNT_W-1:0] best_stamp;

  // Row data
  entry_t [WAYS-1:0] row_rd;
  entry_t [WAYS-1:0] row_wr;

  logic [ADDR_W-1:0] line_num;
  logic [SET_W-1:0]  req_set;
  logic [WAYS-1:0]   hit_vec;
  logic [WAYS-1:0]   inv_vec;
  logic [WAY_W-1:0]  hit_way;
  logic [WAY_W-1:0]  inv_way;
  logic [WAY_W-1:0]  look_way;
  logic [WAY_W-1:0]  commit_way;
  logic              any_hit;
  logic              any_inv;
  logic              commit;
  logic [CNT_W-1:0]  access_next;
  logic              wr_en;
  logic [SET_W-1:0]  wr_addr;

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      line_size_log2 <= RST_LINE_SIZE_LOG2;
      lru_mode       <= RST_LRU_MODE;
      hit_latency    <= RST_HIT_LATENCY;
      miss_latency   <= RST_MISS_LATENCY;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_LINE_SIZE_LOG2: line_size_log2 <= cfg_data[LS_W-1:0];
        REG_LRU_MODE:       lru_mode       <= cfg_data[0];
        REG_HIT_LATENCY:    hit_latency    <= cfg_data[LAT_W-1:0];
        REG_MISS_LATENCY:   miss_latency   <= cfg_data[LAT_W-1:0];
        default: ;
      endcase
    end
  end

  // Address split: line address, set index, tag
  assign line_num = address >> line_size_log2;
  assign req_set  = SET_W'(line_num & ADDR_W'(SETS - 1));

  always_ff @(posedge clk) begin
    if (cmd.lookup) begin
      set_q <= req_set;
      tag_q <= TAG_W'(line_num >> SET_BITS);
    end
  end

  // Tag compare and first invalid way
  always_comb begin
    hit_way = '0;
    inv_way = '0;
    for (int w = 0; w < WAYS; w++) begin
      hit_vec[w] = row_rd[w].valid && (row_rd[w].tag == tag_q);
      inv_vec[w] = !row_rd[w].valid;
    end
    for (int w = WAYS - 1; w >= 0; w--) begin
      if (hit_vec[w]) hit_way = WAY_W'(w);
      if (inv_vec[w]) inv_way = WAY_W'(w);
    end
  end

  assign any_hit = |hit_vec;
  assign any_inv = |inv_vec;

  // Way decided without a scan: hit, way 0 with LRU off, or first free way
  always_comb begin
    if (any_hit)            look_way = hit_way;
    else if (!lru_mode)     look_way = '0;
    else if (any_inv)       look_way = inv_way;
    else                    look_way = '0;
  end

  // Stamp scan over a full set, one way per cycle, ties to the lower way
  always_ff @(posedge clk) begin
    if (cmd.scan_start) begin
      scan_idx   <= WAY_W'(1);
      best_way   <= '0;
      best_stamp <= row_rd[0].stamp;
    end else if (cmd.scan_step) begin
      scan_idx <= scan_idx + WAY_W'(1);
      if (row_rd[scan_idx].stamp < best_stamp) begin
        best_way   <= scan_idx;
        best_stamp <= row_rd[scan_idx].stamp;
      end
    end
  end

  assign commit      = cmd.look_done | cmd.fill_done;
  assign commit_way  = cmd.fill_done ? best_way : look_way;
  assign access_next = access_count + CNT_W'(1);

  // Row written back: zero row while clearing, else installed tag, valid, stamp in LRU mode
  always_comb begin
    row_wr = row_rd;
    if (cmd.clear_row) begin
      row_wr = '0;
    end else begin
      row_wr[commit_way].valid = 1'b1;
      row_wr[commit_way].tag   = tag_q;
      if (lru_mode) row_wr[commit_way].stamp = access_next;
    end
  end

  assign wr_en   = cmd.clear_row | commit;
  assign wr_addr = cmd.clear_row ? clr_cnt : set_q;

  salru_ram #(
    .WIDTH (ROW_W),
    .DEPTH (SETS)
  ) u_row_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (row_wr),
    .rd_en   (cmd.lookup),
    .rd_addr (req_set),
    .rd_data (row_rd)
  );

  // Clearing pointer and counters
  always_ff @(posedge clk) begin
    if (rst) begin
      clr_cnt      <= '0;
      access_count <= '0;
      hit_count    <= '0;
      miss_count   <= '0;
    end else begin
      if (cmd.clear_row) clr_cnt <= clr_cnt + SET_W'(1);
      if (commit) begin
        access_count <= access_next;
        if (any_hit && cmd.look_done) hit_count  <= hit_count + CNT_W'(1);
        else                          miss_count <= miss_count + CNT_W'(1);
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (commit) begin
      rsp_valid <= 1'b1;
    end else if (!rsp_stall) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      hit      <= any_hit && cmd.look_done;
      latency  <= (any_hit && cmd.look_done) ? hit_latency : miss_latency;
      way_used <= WAY_OUT_W'(commit_way);
      if (any_hit && cmd.look_done) begin
        hit_total  <= hit_count + CNT_W'(1);
        miss_total <= miss_count;
      end else begin
        hit_total  <= hit_count;
        miss_total <= miss_count + CNT_W'(1);
      end
    end
  end

  // Status
  assign status.clear_last = (clr_cnt == SET_W'(SETS - 1));
  assign status.look_final = any_hit || !lru_mode || any_inv || (WAYS == 1);
  assign status.scan_last  = (scan_idx == WAY_W'(WAYS - 1));
  assign status.out_free   = !rsp_valid || !rsp_stall;

endmodule

// ----- design/salru_ctrl.sv -----
// ---------------------------------------------------------------------------
// salru_ctrl: controller of the LRU cache tag lookup
// Sequences the clearing pass, request intake, lookup, stamp scan and
// result handoff.
// ---------------------------------------------------------------------------
module salru_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  req_valid,
  output logic                  req_stall,
  input  salru_pkg::dp_status_t status,
  output salru_pkg::dp_cmd_t    cmd
);
  import salru_pkg::*;

  typedef enum logic [4:0] {
    ST_CLEAR = 5'b00001,
    ST_IDLE  = 5'b00010,
    ST_LOOK  = 5'b00100,
    ST_SCAN  = 5'b01000,
    ST_FILL  = 5'b10000
  } state_t;

  state_t state;
  state_t state_next;

  // State register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  // Next state and commands
  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      ST_CLEAR: begin
        cmd.clear_row = 1'b1;
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (req_valid) begin
          cmd.lookup = 1'b1;
          state_next = ST_LOOK;
        end
      end
      ST_LOOK: begin
        if (status.look_final) begin
          if (status.out_free) begin
            cmd.look_done = 1'b1;
            state_next    = ST_IDLE;
          end
        end else begin
          cmd.scan_start = 1'b1;
          state_next     = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cmd.scan_step = 1'b1;
        if (status.scan_last) state_next = ST_FILL;
      end
      ST_FILL: begin
        if (status.out_free) begin
          cmd.fill_done = 1'b1;
          state_next    = ST_IDLE;
        end
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  assign req_stall = (state != ST_IDLE);

endmodule

// ----- design/set_assoc_cache_lru_lookup.sv -----
// ---------------------------------------------------------------------------
// set_assoc_cache_lru_lookup: set-associative cache tag lookup with LRU
// Takes one byte address per request and returns hit/miss, latency, the
// way used and running hit and miss totals.
// ---------------------------------------------------------------------------
// After reset the block runs a clearing pass over all SETS rows of the
// set RAM and holds req_stall high meanwhile; configuration writes are taken
// at any time (cfg_ready is always high) but must only be issued while
// the block is idle. A request first reads the set row from the
// single-port-read RAM, then compares tags, chooses the way and writes the
// row back. A miss on a full set in LRU mode adds a victim stamp search
// that walks one way per cycle. A result waiting in the output register
// does not block the next request from being taken; it only holds the
// commit of that next one.
// ---------------------------------------------------------------------------
module set_assoc_cache_lru_lookup #(
  parameter int SETS = salru_pkg::DEF_SETS,
  parameter int WAYS = salru_pkg::DEF_WAYS
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              req_valid,
  output logic                              req_stall,
  input  logic [salru_pkg::ADDR_W-1:0]      address,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [salru_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [salru_pkg::CFG_DATA_W-1:0]  cfg_data,
  output logic                              rsp_valid,
  input  logic                              rsp_stall,
  output logic                              hit,
  output logic [salru_pkg::LAT_W-1:0]       latency,
  output logic [salru_pkg::WAY_OUT_W-1:0]   way_used,
  output logic [salru_pkg::CNT_W-1:0]       hit_total,
  output logic [salru_pkg::CNT_W-1:0]       miss_total
);
  import salru_pkg::*;

  dp_cmd_t    cmd;
  dp_status_t status;

  assign cfg_ready = 1'b1;

  // Sequencer
  salru_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .status    (status),
    .cmd       (cmd)
  );

  // Lookup datapath
  salru_dp #(
    .SETS (SETS),
    .WAYS (WAYS)
  ) u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .status     (status),
    .address    (address),
    .cfg_valid  (cfg_valid & cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .rsp_valid  (rsp_valid),
    .rsp_stall  (rsp_stall),
    .hit        (hit),
    .latency    (latency),
    .way_used   (way_used),
    .hit_total  (hit_total),
    .miss_total (miss_total)
  );

endmodule

// ----- verif/testbench.sv -----
// ---------------------------------------------------------------------------
// testbench: set_assoc_cache_lru_lookup verification
// Drives byte addresses through the request channel and register writes
// through the config channel, predicts each lookup with a local model of
// the tag store, valid bits, LRU stamps and counters, and compares every
// response field against the oldest outstanding prediction. The request
// channel sees random gaps and the response channel random stalls.
// ---------------------------------------------------------------------------
module testbench;
  import salru_pkg::*;

  localparam int SETS         = DEF_SETS;
  localparam int WAYS         = DEF_WAYS;
  localparam int SET_W        = $clog2(SETS);
  localparam int ENTRIES      = SETS * WAYS;
  localparam int DRAIN_CYCLES = WAYS + 4;
  localparam int STALL_LIMIT  = 2000;
  localparam int POOL_SIZE    = 8;
  localparam int PHASES       = 8;
  localparam int PHASE_ITEMS  = 156;

  // indexes past the register file, writes there must be dropped
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_FIRST = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LAST  = 4'd15;

  typedef struct packed {
    logic                 hit;
    logic [LAT_W-1:0]     latency;
    logic [WAY_OUT_W-1:0] way_used;
    logic [CNT_W-1:0]     hit_total;
    logic [CNT_W-1:0]     miss_total;
  } lookup_result_t;

  // DUT signals
  logic                  clk       = 1'b0;
  logic                  rst       = 1'b1;
  logic                  req_valid = 1'b0;
  logic                  req_stall;
  logic [ADDR_W-1:0]     address   = '0;
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;
  logic                  rsp_valid;
  logic                  rsp_stall = 1'b0;
  logic                  hit;
  logic [LAT_W-1:0]      latency;
  logic [WAY_OUT_W-1:0]  way_used;
  logic [CNT_W-1:0]      hit_total;
  logic [CNT_W-1:0]      miss_total;

  // cache model
  logic [TAG_W-1:0] model_tags   [ENTRIES] = '{default: '0};
  bit               model_valid  [ENTRIES] = '{default: 1'b0};
  logic [CNT_W-1:0] model_stamps [ENTRIES] = '{default: '0};
  logic [CNT_W-1:0] access_count = '0;
  logic [CNT_W-1:0] hit_count    = '0;
  logic [CNT_W-1:0] miss_count   = '0;

  // register copies
  logic [LS_W-1:0]  line_log2    = RST_LINE_SIZE_LOG2;
  logic             lru_on       = RST_LRU_MODE;
  logic [LAT_W-1:0] hit_lat      = RST_HIT_LATENCY;
  logic [LAT_W-1:0] miss_lat     = RST_MISS_LATENCY;

  lookup_result_t   pending_lookups[$];
  logic [TAG_W-1:0] tag_pool[POOL_SIZE];
  int               error_count  = 0;
  int               idle_cycles  = 0;
  int               stall_left   = 0;
  bit               quiet        = 1'b0;

  set_assoc_cache_lru_lookup #(
    .SETS(SETS),
    .WAYS(WAYS)
  ) u_dut (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .address   (address),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .hit       (hit),
    .latency   (latency),
    .way_used  (way_used),
    .hit_total (hit_total),
    .miss_total(miss_total)
  );

  always #5 clk = ~clk;

  // Lookup prediction: search the set, update counters, pick victim on miss
  function automatic lookup_result_t predict_lookup(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] line;
    logic [TAG_W-1:0]  tag;
    logic [CNT_W:0]    best_stamp;
    lookup_result_t    r;
    int                base;
    int                way;
    int                first_free;
    int                oldest;
    bit                found;
    line  = addr >> line_log2;
    base  = int'(line % SETS) * WAYS;
    tag   = line / SETS;
    found = 1'b0;
    way   = 0;
    access_count = access_count + 1'b1;
    for (int w = 0; w < WAYS; w++) begin
      if (!found && model_valid[base + w] && model_tags[base + w] == tag) begin
        found = 1'b1;
        way   = w;
      end
    end
    if (found) begin
      hit_count = hit_count + 1'b1;
    end else begin
      miss_count = miss_count + 1'b1;
      if (lru_on) begin
        // lowest invalid way wins, else the oldest stamp (ties to lowest way)
        first_free = -1;
        oldest     = 0;
        best_stamp = '1;
        for (int w = 0; w < WAYS; w++) begin
          if (first_free < 0 && !model_valid[base + w]) first_free = w;
          if ({1'b0, model_stamps[base + w]} < best_stamp) begin
            best_stamp = {1'b0, model_stamps[base + w]};
            oldest     = w;
          end
        end
        way = (first_free >= 0) ? first_free : oldest;
      end
      model_valid[base + way] = 1'b1;
      model_tags[base + way]  = tag;
    end
    if (lru_on) model_stamps[base + way] = access_count;
    r.hit        = found;
    r.latency    = found ? hit_lat : miss_lat;
    r.way_used   = way[WAY_OUT_W-1:0];
    r.hit_total  = hit_count;
    r.miss_total = miss_count;
    return r;
  endfunction

  // Register write as the block sees it, upper bits masked off
  function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                         input logic [CFG_DATA_W-1:0] data);
    case (idx)
      REG_LINE_SIZE_LOG2: line_log2 = data[LS_W-1:0];
      REG_LRU_MODE:       lru_on    = data[0];
      REG_HIT_LATENCY:    hit_lat   = data[LAT_W-1:0];
      REG_MISS_LATENCY:   miss_lat  = data[LAT_W-1:0];
      default: ;
    endcase
  endfunction

  function automatic logic [ADDR_W-1:0] rand48();
    return {16'($urandom), 32'($urandom)};
  endfunction

  // mostly short gaps, some long ones, none in a quiet stretch
  function automatic int pick_gap();
    int r;
    if (quiet) return 0;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Byte address for a given tag, set and offset under the current line size
  function automatic logic [ADDR_W-1:0] make_address(input logic [TAG_W-1:0] tag, input int set,
                                                     input logic [ADDR_W-1:0] offs);
    logic [ADDR_W-1:0] line;
    line = (tag << SET_W) | ADDR_W'(set);
    return (line << line_log2) | (offs & ((48'd1 << line_log2) - 1'b1));
  endfunction

  // Mostly a small working set crowded into a few sets, some fully random
  function automatic logic [ADDR_W-1:0] random_address();
    int set;
    if ($urandom_range(0, 99) < 15) return rand48();
    if ($urandom_range(0, 31) == 0) tag_pool[$urandom_range(0, POOL_SIZE - 1)] = rand48();
    set = ($urandom_range(0, 3) == 0) ? $urandom_range(0, SETS - 1) : $urandom_range(0, 2);
    return make_address(tag_pool[$urandom_range(0, POOL_SIZE - 1)], set, rand48());
  endfunction

  function automatic void check_field(input string name, input logic [CNT_W-1:0] want,
                                      input logic [CNT_W-1:0] got);
    if (got !== want) begin
      $error("%s mismatch: expected %0h, got %0h", name, want, got);
      error_count++;
    end
  endfunction

  // Send one request; caller sits just after a falling edge
  task automatic send_request(input logic [ADDR_W-1:0] addr);
    int gap;
    address   <= addr;
    req_valid <= 1'b1;
    do @(posedge clk); while (req_stall);
    pending_lookups.push_back(predict_lookup(addr));
    @(negedge clk);
    gap = pick_gap();
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  task automatic write_register(input logic [CFG_IDX_W-1:0] idx,
                                input logic [CFG_DATA_W-1:0] data);
    cfg_index <= idx;
    cfg_data  <= data;
    cfg_valid <= 1'b1;
    do @(posedge clk); while (!cfg_ready);
    apply_register(idx, data);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_config(input logic [LS_W-1:0] ls, input logic lru,
                            input logic [LAT_W-1:0] hl, input logic [LAT_W-1:0] ml);
    write_register(REG_LINE_SIZE_LOG2, {4'($urandom), ls});
    write_register(REG_LRU_MODE, {7'($urandom), lru});
    write_register(REG_HIT_LATENCY, hl);
    write_register(REG_MISS_LATENCY, ml);
  endtask

  // Drain all outstanding responses, then let a victim scan settle
  task automatic wait_idle();
    req_valid <= 1'b0;
    while (pending_lookups.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // Reset settings: extremes of the address, same-line hit, fill and evict
  task automatic test_reset_defaults();
    send_request('0);
    send_request('1);
    send_request(48'h3F);
    for (int k = 1; k <= WAYS; k++) send_request(make_address(TAG_W'(k), 5, 48'd0));
    send_request(make_address(48'd1, 5, 48'd7));
    send_request(make_address(48'd5, 5, 48'd0));
    send_request(make_address(48'd2, 5, 48'd0));
  endtask

  // Masking, ignored indexes, latency extremes, smallest and largest line
  task automatic test_register_writes();
    wait_idle();
    write_register(REG_LINE_SIZE_LOG2, 8'hF0);
    write_register(REG_HIT_LATENCY, 8'hFF);
    write_register(REG_MISS_LATENCY, 8'h00);
    write_register(REG_LRU_MODE, 8'hFF);
    write_register(REG_SPARE_FIRST, 8'hAA);
    write_register(REG_SPARE_LAST, 8'h55);
    send_request(48'h7);
    send_request(48'h7);
    send_request(48'h6);
    wait_idle();
    write_register(REG_LINE_SIZE_LOG2, 8'h0F);
    send_request(48'h8000);
    send_request(48'h7FFF);
    wait_idle();
    write_register(REG_LINE_SIZE_LOG2, 8'd12);
    send_request(48'hABC_DEF1_2345);
  endtask

  // LRU off always fills way 0 and keeps old stamps for when LRU returns
  task automatic test_lru_switch();
    wait_idle();
    set_config(4'd6, 1'b1, 8'd1, 8'd10);
    for (int k = 1; k <= WAYS; k++) send_request(make_address(TAG_W'(k + 16), 20, 48'd0));
    wait_idle();
    write_register(REG_LRU_MODE, 8'h00);
    send_request(make_address(48'd21, 20, 48'd0));
    send_request(make_address(48'd21, 20, 48'd3));
    wait_idle();
    write_register(REG_LRU_MODE, 8'h01);
    send_request(make_address(48'd22, 20, 48'd0));
  endtask

  // Random traffic over several settings, with quiet stretches
  task automatic test_random_traffic();
    logic [LS_W-1:0]  ls_plan  [PHASES] = '{4'd6, 4'd0, 4'd12, 4'd15, 4'd3, 4'd6, 4'd9, 4'd1};
    logic             lru_plan [PHASES] = '{1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b0, 1'b1};
    logic [LAT_W-1:0] hl;
    logic [LAT_W-1:0] ml;
    for (int i = 0; i < POOL_SIZE; i++) tag_pool[i] = rand48();
    for (int p = 0; p < PHASES; p++) begin
      wait_idle();
      hl = (p == 1) ? 8'd0 : (p == 2) ? 8'd255 : (p == 0) ? 8'd1 : 8'($urandom);
      ml = (p == 1) ? 8'd255 : (p == 2) ? 8'd0 : (p == 0) ? 8'd10 : 8'($urandom);
      set_config(ls_plan[p], lru_plan[p], hl, ml);
      for (int i = 0; i < PHASE_ITEMS; i++) begin
        if (i % 40 == 0) quiet = ($urandom_range(0, 3) == 0);
        send_request(random_address());
      end
    end
    quiet = 1'b0;
  endtask

  // Response side back-pressure
  always @(negedge clk) begin
    if (stall_left == 0 && !quiet && $urandom_range(0, 99) < 30) stall_left = pick_gap();
    if (stall_left > 0) begin
      rsp_stall <= 1'b1;
      stall_left--;
    end else begin
      rsp_stall <= 1'b0;
    end
  end

  // Response check against the oldest prediction
  always @(posedge clk) begin
    lookup_result_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_lookups.size() == 0) begin
        $error("response with no request outstanding");
        error_count++;
      end else begin
        want = pending_lookups.pop_front();
        check_field("hit", CNT_W'(want.hit), CNT_W'(hit));
        check_field("latency", CNT_W'(want.latency), CNT_W'(latency));
        check_field("way_used", CNT_W'(want.way_used), CNT_W'(way_used));
        check_field("hit_total", want.hit_total, hit_total);
        check_field("miss_total", want.miss_total, miss_total);
      end
    end
  end

  // Watchdog: too long without any handshake on any channel
  always @(posedge clk) begin
    if (rst || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
        (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles == STALL_LIMIT) begin
      $display("** set_assoc_cache_lru_lookup: FAILED **");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_reset_defaults();
    test_register_writes();
    test_lru_switch();
    test_random_traffic();
    wait_idle();
    if (error_count == 0) begin
      $display("** set_assoc_cache_lru_lookup: PASSED **");
    end else begin
      $display("** set_assoc_cache_lru_lookup: FAILED **");
    end
    $finish;
  end

endmodule
